// ===== hw/rtl/sm3_pkg.sv =====
`timescale 1ns / 1ps

package sm3_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumWords = 16;
  localparam int unsigned NumChain = 8;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned OutDataW = 40;

  localparam logic [WordW-1:0] TLow = 32'h79CC4519;
  localparam logic [WordW-1:0] THigh = 32'h7A879D8A;
  // THigh rotated left by 16, the constant that round 16 starts from.
  localparam logic [WordW-1:0] THighRot16 = 32'h9D8A7A87;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Iv [NumChain] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StOut
  } state_e;

  function automatic word_t perm_p0(input word_t x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic word_t perm_p1(input word_t x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage

// ===== hw/rtl/sm3_block_compression.sv =====
`timescale 1ns / 1ps
// A block passes through three phases: 16 input transfers, then the 64 rounds, then 8 output transfers;
// a new 512-bit block is accepted only after the last output transfer of the previous one.
// Throughput is set by the single round unit, which runs one SM3 round per cycle.
// The input is ready only while words of a block are being collected.
// Reset (rst_ni low, asynchronous) loads the SM3 initial value as chaining value,
// clears the word count and sets the restart flag so the first block starts from it.
module sm3_block_compression
  import sm3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [WordW-1:0]    s_axis_tdata_i,   // [31:0] message_word
  input  logic                s_axis_tuser_i,   // [0] new_message
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic                m_axis_tlast_o    // last_word
);

  state_e state_q, state_d;

  word_t       cv_q   [NumChain];
  word_t       cv_d   [NumChain];
  word_t       work_q [NumChain];
  word_t       work_d [NumChain];
  // Message window: entry 0 holds W[j] of the current round, entry 15 the newest word.
  word_t       win_q  [NumWords];
  word_t       win_d  [NumWords];
  word_t       tj_q, tj_d;
  logic [3:0]  word_cnt_q, word_cnt_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        restart_q, restart_d;

  logic        in_xfer;
  logic        out_xfer;
  logic [3:0]  word_base;
  logic        block_done;

  // Round unit signals.
  logic        early;
  word_t       a_rot12;
  word_t       ff, gg, ss1, ss2, tt1, tt2, w_next, ss1_pre;

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer   = m_axis_tvalid_o && m_axis_tready_i;
  // A word flagged as new_message always becomes word 0 of a fresh block.
  assign word_base  = s_axis_tuser_i ? 4'd0 : word_cnt_q;
  assign block_done = in_xfer && (word_base == 4'd15);

  // One SM3 round, reused for all 64 rounds.
  always_comb begin
    early   = (round_q[5:4] == 2'd0);
    a_rot12 = {work_q[0][19:0], work_q[0][31:20]};
    ff      = early ? (work_q[0] ^ work_q[1] ^ work_q[2])
                    : ((work_q[0] & work_q[1]) | (work_q[0] & work_q[2]) |
                       (work_q[1] & work_q[2]));
    gg      = early ? (work_q[4] ^ work_q[5] ^ work_q[6])
                    : ((work_q[4] & work_q[5]) | (~work_q[4] & work_q[6]));
    ss1_pre = a_rot12 + work_q[4] + tj_q;
    ss1     = {ss1_pre[24:0], ss1_pre[31:25]};
    ss2     = ss1 ^ a_rot12;
    tt1     = ff + work_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2     = gg + work_q[7] + ss1 + win_q[0];
    // Next expanded word, W[j+16] from the window taps.
    w_next  = perm_p1(win_q[0] ^ win_q[7] ^ {win_q[13][16:0], win_q[13][31:17]})
            ^ {win_q[3][24:0], win_q[3][31:25]} ^ win_q[10];
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (block_done) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (round_q == 6'(NumRounds - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_xfer && (out_idx_q == 3'(NumChain - 1))) begin
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Handshake outputs and the result word; the digest is the chaining value XOR the rounds.
  always_comb begin
    s_axis_tready_o = (state_q == StLoad);
    m_axis_tvalid_o = (state_q == StOut);
    m_axis_tlast_o  = (out_idx_q == 3'(NumChain - 1));
    m_axis_tdata_o  = {5'd0, out_idx_q, cv_q[out_idx_q] ^ work_q[out_idx_q]};
  end

  // Datapath next values.
  always_comb begin
    cv_d       = cv_q;
    work_d     = work_q;
    win_d      = win_q;
    tj_d       = tj_q;
    word_cnt_d = word_cnt_q;
    round_d    = round_q;
    out_idx_d  = out_idx_q;
    restart_d  = restart_q;

    unique case (state_q)
      StLoad: begin
        if (in_xfer) begin
          for (int i = 0; i < NumWords - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[NumWords-1] = s_axis_tdata_i;
          word_cnt_d = word_base + 4'd1;
          if ((word_base == 4'd0) && (s_axis_tuser_i || restart_q)) begin
            cv_d      = Iv;
            restart_d = 1'b0;
          end
          if (block_done) begin
            work_d  = cv_q;
            tj_d    = TLow;
            round_d = '0;
          end
        end
      end
      StRound: begin
        work_d[0] = tt1;
        work_d[1] = work_q[0];
        work_d[2] = {work_q[1][22:0], work_q[1][31:23]};
        work_d[3] = work_q[2];
        work_d[4] = perm_p0(tt2);
        work_d[5] = work_q[4];
        work_d[6] = {work_q[5][12:0], work_q[5][31:13]};
        work_d[7] = work_q[6];
        for (int i = 0; i < NumWords - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[NumWords-1] = w_next;
        // The round constant rotates by one per round and switches at round 16.
        tj_d    = (round_q == 6'd15) ? THighRot16 : {tj_q[30:0], tj_q[31]};
        round_d = round_q + 6'd1;
        out_idx_d = '0;
      end
      StOut: begin
        if (out_xfer) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'(NumChain - 1)) begin
            for (int i = 0; i < NumChain; i++) begin
              cv_d[i] = cv_q[i] ^ work_q[i];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      cv_q       <= Iv;
      word_cnt_q <= '0;
      round_q    <= '0;
      out_idx_q  <= '0;
      restart_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      cv_q       <= cv_d;
      word_cnt_q <= word_cnt_d;
      round_q    <= round_d;
      out_idx_q  <= out_idx_d;
      restart_q  <= restart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
    tj_q   <= tj_d;
  end

endmodule
